/* hdl/vn2o_pkg.sv */
// Shared constants and types for the two-octave value noise pipeline.
// No dependencies; used by vn2o_octave and value_noise_two_octave.

package vn2o_pkg;

    // Q0.16 fraction and Q0.24 noise value types.
    typedef logic [15:0] q16_t;
    typedef logic [23:0] q24_t;

    // Lattice hash multipliers.
    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Z   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_S   = 32'd2246822519;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

    // Octave-two coordinate transform: scale 2.3 and offsets 17.1 and 3.7.
    localparam logic signed [18:0] OCT2_SCALE = 19'sd150733;
    localparam logic [31:0]        OCT2_OFF_X = 32'd1120666;
    localparam logic [31:0]        OCT2_OFF_Z = 32'd242483;

    // Octave mix weights 0.65 and 0.35 in Q0.16.
    localparam logic [15:0] WEIGHT_ONE = 16'd42598;
    localparam logic [15:0] WEIGHT_TWO = 16'd22938;

    // Fade polynomial constant 3.0 and blend constant 1.0 in Q.16.
    localparam logic [17:0] FADE_THREE = 18'd196608;
    localparam logic [16:0] ONE_Q16    = 17'd65536;

    // Register stages inside one octave and from accept to done.
    localparam int OCT_LATENCY  = 8;
    localparam int PIPE_LATENCY = 13;

endpackage

/* hdl/value_noise_two_octave.sv */
// Top level of the two-octave value noise pipeline.
// Depends on vn2o_pkg and instantiates vn2o_octave twice.
//
//   Channel   Handshake          Word fields
//   -------   ----------------   -------------------------------------
//   input     start / busy       coord_x, coord_z, noise_seed
//   result    done (strobe)      noise_value
//
// One word is taken per cycle while busy is low; each gives one result.
// The depth is set by the octave datapath: two hash multiplies and two
// blend multiplies, each in its own stage, after input capture and two
// stages of octave-two coordinate scaling, and two stages of octave mixing.
// Reset clears all valid bits; busy is high only while reset is applied and
// in the first cycle after it. The receiver cannot stall; done is a
// one-cycle strobe with noise_value beside it.

module value_noise_two_octave
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_z,
    input  logic [31:0]        noise_seed,
    output logic               done,
    output logic [23:0]        noise_value
);

    logic accept;
    logic busy_reg;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // Stage A: input capture.
    logic signed [31:0] xa_reg;
    logic signed [31:0] za_reg;
    logic [31:0]        seeda_reg;
    logic               va_reg;

    // Stage B: octave-two coordinate scaling by 2.3.
    logic signed [50:0] sx_prod;
    logic signed [50:0] sz_prod;
    logic [31:0]        sxb_reg;
    logic [31:0]        szb_reg;
    logic [31:0]        xb_reg;
    logic [31:0]        zb_reg;
    logic [31:0]        seedb_reg;
    logic               vb_reg;

    assign sx_prod = xa_reg * vn2o_pkg::OCT2_SCALE;
    assign sz_prod = za_reg * vn2o_pkg::OCT2_SCALE;

    // Stage C: octave-two offsets and seed, octave-one operands aligned.
    logic [31:0] x2_next;
    logic [31:0] z2_next;
    logic [31:0] seed2_next;
    logic [31:0] x1c_reg;
    logic [31:0] z1c_reg;
    logic [31:0] seed1c_reg;
    logic [31:0] x2c_reg;
    logic [31:0] z2c_reg;
    logic [31:0] seed2c_reg;
    logic        vc_reg;

    assign x2_next    = sxb_reg + vn2o_pkg::OCT2_OFF_X;
    assign z2_next    = szb_reg - vn2o_pkg::OCT2_OFF_Z;
    assign seed2_next = seedb_reg + 32'd1;

    // The two octaves run side by side with equal latency.
    logic            oct1_valid;
    logic            oct2_valid;
    vn2o_pkg::q24_t  n1;
    vn2o_pkg::q24_t  n2;

    vn2o_octave u_oct1
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vc_reg),
        .x         (x1c_reg),
        .z         (z1c_reg),
        .seed      (seed1c_reg),
        .out_valid (oct1_valid),
        .noise     (n1)
    );

    vn2o_octave u_oct2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vc_reg),
        .x         (x2c_reg),
        .z         (z2c_reg),
        .seed      (seed2c_reg),
        .out_valid (oct2_valid),
        .noise     (n2)
    );

    // Mix stage 1: weight each octave.
    logic [39:0] w1_next;
    logic [39:0] w2_next;
    logic [39:0] w1_reg;
    logic [39:0] w2_reg;
    logic        vm_reg;

    assign w1_next = 40'(n1) * 40'(vn2o_pkg::WEIGHT_ONE);
    assign w2_next = 40'(n2) * 40'(vn2o_pkg::WEIGHT_TWO);

    // Mix stage 2: sum and scale back to Q0.24.
    logic [40:0]    mix_sum;
    vn2o_pkg::q24_t noise_next;
    vn2o_pkg::q24_t noise_value_reg;
    logic           done_reg;

    assign mix_sum    = 41'(w1_reg) + 41'(w2_reg);
    assign noise_next = mix_sum[39:16];

    // Control registers: busy and the valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vm_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            va_reg   <= accept;
            vb_reg   <= va_reg;
            vc_reg   <= vb_reg;
            vm_reg   <= oct1_valid;
            done_reg <= vm_reg;
        end
    end

    // Input word capture, loaded only on accept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xa_reg    <= coord_x;
            za_reg    <= coord_z;
            seeda_reg <= noise_seed;
        end
    end

    // Payload pipeline registers.
    always_ff @(posedge clk)
    begin
        sxb_reg    <= sx_prod[47:16];
        szb_reg    <= sz_prod[47:16];
        xb_reg     <= xa_reg;
        zb_reg     <= za_reg;
        seedb_reg  <= seeda_reg;

        x1c_reg    <= xb_reg;
        z1c_reg    <= zb_reg;
        seed1c_reg <= seedb_reg;
        x2c_reg    <= x2_next;
        z2c_reg    <= z2_next;
        seed2c_reg <= seed2_next;

        w1_reg     <= w1_next;
        w2_reg     <= w2_next;

        noise_value_reg <= noise_next;
    end

    assign done        = done_reg;
    assign noise_value = noise_value_reg;

    // A result only appears a fixed depth after a word was taken.
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, vn2o_pkg::PIPE_LATENCY))
        else $error("done without a word taken at the pipeline depth");

    // Both octave pipelines must stay in lockstep.
    a_octaves_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        oct1_valid == oct2_valid)
        else $error("octave pipelines out of step");

    // The octave output lines up with the word that entered it.
    a_octave_depth: assert property (@(posedge clk) disable iff (!rst_n)
        oct1_valid |-> $past(vc_reg, vn2o_pkg::OCT_LATENCY))
        else $error("octave result without matching entry");

    // Once out of reset, the block always takes words.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> !busy)
        else $error("busy raised after reset");

endmodule

/* hdl/vn2o_octave.sv */
// One octave of 2D value noise as an eight-stage pipeline.
// Depends on vn2o_pkg for hash constants and fixed-point types.

module vn2o_octave
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [31:0]        x,
    input  logic [31:0]        z,
    input  logic [31:0]        seed,
    output logic               out_valid,
    output vn2o_pkg::q24_t     noise
);

    // Stage 1: cell products of the hash and the fraction squares.
    logic [31:0]     cx_ext;
    logic [31:0]     cz_ext;
    logic [31:0]     px_next;
    logic [31:0]     pz_next;
    logic [31:0]     ps_next;
    logic [31:0]     ffx_next;
    logic [31:0]     ffz_next;
    logic [31:0]     px_reg;
    logic [31:0]     pz_reg;
    logic [31:0]     ps_reg;
    vn2o_pkg::q16_t  f2x_reg;
    vn2o_pkg::q16_t  f2z_reg;
    vn2o_pkg::q16_t  fx_reg;
    vn2o_pkg::q16_t  fz_reg;
    logic            v1_reg;

    assign cx_ext   = {{16{x[31]}}, x[31:16]};
    assign cz_ext   = {{16{z[31]}}, z[31:16]};
    assign px_next  = cx_ext * vn2o_pkg::HASH_MUL_X;
    assign pz_next  = cz_ext * vn2o_pkg::HASH_MUL_Z;
    assign ps_next  = seed * vn2o_pkg::HASH_MUL_S;
    assign ffx_next = 32'(x[15:0]) * 32'(x[15:0]);
    assign ffz_next = 32'(z[15:0]) * 32'(z[15:0]);

    // Stage 2: base hash sum and the second fade multiply.
    logic [31:0]     base_next;
    logic [17:0]     fade_tx;
    logic [17:0]     fade_tz;
    logic [33:0]     fpx_next;
    logic [33:0]     fpz_next;
    logic [31:0]     base_reg;
    vn2o_pkg::q16_t  tx2_reg;
    vn2o_pkg::q16_t  tz2_reg;
    logic            v2_reg;

    assign base_next = px_reg + pz_reg + ps_reg;
    assign fade_tx   = vn2o_pkg::FADE_THREE - {1'b0, fx_reg, 1'b0};
    assign fade_tz   = vn2o_pkg::FADE_THREE - {1'b0, fz_reg, 1'b0};
    assign fpx_next  = 34'(f2x_reg) * 34'(fade_tx);
    assign fpz_next  = 34'(f2z_reg) * 34'(fade_tz);

    // Stage 3: corner sums and the first xor-shift.
    logic [31:0]     h_corner [4];
    logic [31:0]     g_next   [4];
    logic [31:0]     g_reg    [4];
    vn2o_pkg::q16_t  tx3_reg;
    vn2o_pkg::q16_t  tz3_reg;
    logic            v3_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            h_corner[k] = base_reg
                        + (((k & 1) != 0) ? vn2o_pkg::HASH_MUL_X : 32'd0)
                        + (((k & 2) != 0) ? vn2o_pkg::HASH_MUL_Z : 32'd0);
            g_next[k]   = h_corner[k] ^ (h_corner[k] >> 13);
        end
    end

    // Stage 4: hash mixing multiply for each corner.
    logic [31:0]     m_next [4];
    logic [31:0]     m_reg  [4];
    vn2o_pkg::q16_t  tx4_reg;
    vn2o_pkg::q16_t  tz4_reg;
    logic            v4_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            m_next[k] = g_reg[k] * vn2o_pkg::HASH_MUL_MIX;
        end
    end

    // Stage 5: final xor-shift and the weighted corner products along X.
    logic [31:0]     m_mix   [4];
    vn2o_pkg::q24_t  corner  [4];
    logic [16:0]     omt_x;
    logic [40:0]     cp_next [4];
    logic [40:0]     cp_reg  [4];
    vn2o_pkg::q16_t  tz5_reg;
    logic            v5_reg;

    assign omt_x = vn2o_pkg::ONE_Q16 - {1'b0, tx4_reg};

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            m_mix[k]  = m_reg[k] ^ (m_reg[k] >> 16);
            corner[k] = m_mix[k][23:0];
            if ((k & 1) != 0)
            begin
                cp_next[k] = 41'(corner[k]) * 41'(tx4_reg);
            end
            else
            begin
                cp_next[k] = 41'(corner[k]) * 41'(omt_x);
            end
        end
    end

    // Stage 6: the two rows blended along X.
    logic [41:0]     row_sum [2];
    vn2o_pkg::q24_t  row_next [2];
    vn2o_pkg::q24_t  row_reg  [2];
    vn2o_pkg::q16_t  tz6_reg;
    logic            v6_reg;

    always_comb
    begin
        for (int r = 0; r < 2; r++)
        begin
            row_sum[r]  = 42'(cp_reg[2 * r]) + 42'(cp_reg[2 * r + 1]);
            row_next[r] = row_sum[r][39:16];
        end
    end

    // Stage 7: weighted row products along Z.
    logic [16:0]     omt_z;
    logic [40:0]     rp0_next;
    logic [40:0]     rp1_next;
    logic [40:0]     rp0_reg;
    logic [40:0]     rp1_reg;
    logic            v7_reg;

    assign omt_z    = vn2o_pkg::ONE_Q16 - {1'b0, tz6_reg};
    assign rp0_next = 41'(row_reg[0]) * 41'(omt_z);
    assign rp1_next = 41'(row_reg[1]) * 41'(tz6_reg);

    // Stage 8: final blend.
    logic [41:0]     blend_sum;
    vn2o_pkg::q24_t  noise_next;
    vn2o_pkg::q24_t  noise_reg;
    logic            v8_reg;

    assign blend_sum  = 42'(rp0_reg) + 42'(rp1_reg);
    assign noise_next = blend_sum[39:16];

    // Valid bits travel with the data and clear on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        pz_reg   <= pz_next;
        ps_reg   <= ps_next;
        f2x_reg  <= ffx_next[31:16];
        f2z_reg  <= ffz_next[31:16];
        fx_reg   <= x[15:0];
        fz_reg   <= z[15:0];

        base_reg <= base_next;
        tx2_reg  <= fpx_next[31:16];
        tz2_reg  <= fpz_next[31:16];

        g_reg    <= g_next;
        tx3_reg  <= tx2_reg;
        tz3_reg  <= tz2_reg;

        m_reg    <= m_next;
        tx4_reg  <= tx3_reg;
        tz4_reg  <= tz3_reg;

        cp_reg   <= cp_next;
        tz5_reg  <= tz4_reg;

        row_reg  <= row_next;
        tz6_reg  <= tz5_reg;

        rp0_reg  <= rp0_next;
        rp1_reg  <= rp1_next;

        noise_reg <= noise_next;
    end

    assign out_valid = v8_reg;
    assign noise     = noise_reg;

endmodule
